// ===== sv/sktab_pkg.sv =====
// Shared types and codes for the sorted key table.
`default_nettype none

package sktab_pkg;

    // Request codes carried in the mode field
    localparam logic [1:0] MODE_INSERT = 2'd0;
    localparam logic [1:0] MODE_SEARCH = 2'd1;
    localparam logic [1:0] MODE_DELETE = 2'd2;

    // Result status codes
    typedef enum logic [1:0] {
        STAT_OK        = 2'd0,
        STAT_DUPLICATE = 2'd1,
        STAT_FULL      = 2'd2,
        STAT_NOT_FOUND = 2'd3
    } sktab_status_t;

    // Request sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_CMP,
        S_RED1,
        S_RED2,
        S_DEC
    } sktab_state_t;

    // Input transaction
    typedef struct packed {
        logic [1:0]  mode;
        logic [31:0] key;
        logic [31:0] payload_in;
    } sktab_in_t;

    // Output transaction
    typedef struct packed {
        logic [1:0]  status;
        logic [8:0]  position;
        logic [31:0] payload_out;
        logic [8:0]  entry_count;
    } sktab_out_t;

    // Broadcast control from the sequencer to every cell
    typedef struct packed {
        logic capture;
        logic ins;
        logic del;
    } sktab_ctl_t;

endpackage

`default_nettype wire

// ===== sv/sktab_cell.sv =====
// One table slot: holds a key and payload, compares against the request, shifts.
`default_nettype none

module sktab_cell #(
    parameter int KEY_WIDTH  = 32,
    parameter int DATA_WIDTH = 32,
    parameter int POS_W      = 9,
    parameter int INDEX      = 0
) (
    input  wire                       clk,
    input  wire                       rst_n,
    input  sktab_pkg::sktab_ctl_t     ctl,
    input  wire                       cmp_signed,
    input  wire  [KEY_WIDTH-1:0]      want_key,
    input  wire  [KEY_WIDTH-1:0]      new_key,
    input  wire  [DATA_WIDTH-1:0]     new_pay,
    input  wire  [POS_W-1:0]          count,
    input  wire  [KEY_WIDTH-1:0]      left_key,
    input  wire  [DATA_WIDTH-1:0]     left_pay,
    input  wire                       left_lt,
    input  wire  [KEY_WIDTH-1:0]      right_key,
    input  wire  [DATA_WIDTH-1:0]     right_pay,
    output logic [KEY_WIDTH-1:0]      key,
    output logic [DATA_WIDTH-1:0]     pay,
    output logic                      lt,
    output logic                      eq
);
    import sktab_pkg::*;

    localparam logic [KEY_WIDTH-1:0] SIGN_MASK = KEY_WIDTH'(1) << (KEY_WIDTH - 1);

    logic [KEY_WIDTH-1:0]  key_reg, key_next;
    logic [DATA_WIDTH-1:0] pay_reg, pay_next;
    logic                  lt_reg, lt_next;
    logic                  eq_reg, eq_next;
    logic                  occupied;
    logic [KEY_WIDTH-1:0]  have_key;

    // Compare the stored key in the table order
    always_comb
    begin
        occupied = count > POS_W'(INDEX);
        have_key = key_reg ^ (cmp_signed ? SIGN_MASK : '0);
        lt_next  = lt_reg;
        eq_next  = eq_reg;
        if (ctl.capture)
        begin
            lt_next = occupied && (have_key < want_key);
            eq_next = occupied && (have_key == want_key);
        end
    end

    // Shift up on insert, down on delete, for every slot at or above the boundary
    always_comb
    begin
        key_next = key_reg;
        pay_next = pay_reg;
        if (ctl.ins && !lt_reg)
        begin
            if (left_lt)
            begin
                key_next = new_key;
                pay_next = new_pay;
            end
            else
            begin
                key_next = left_key;
                pay_next = left_pay;
            end
        end
        else if (ctl.del && !lt_reg)
        begin
            key_next = right_key;
            pay_next = right_pay;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lt_reg <= 1'b0;
            eq_reg <= 1'b0;
        end
        else
        begin
            lt_reg <= lt_next;
            eq_reg <= eq_next;
        end
    end

    // Hold slot contents; no reset needed
    always_ff @(posedge clk)
    begin
        key_reg <= key_next;
        pay_reg <= pay_next;
    end

    assign key = key_reg;
    assign pay = pay_reg;
    assign lt  = lt_reg;
    assign eq  = eq_reg;

endmodule

`default_nettype wire

// ===== sv/sktab_reduce.sv =====
// Two-level registered tree that turns the cell flags into position, hit and payload.
`default_nettype none

module sktab_reduce #(
    parameter int DEPTH      = 256,
    parameter int DATA_WIDTH = 32,
    parameter int POS_W      = 9
) (
    input  wire                          clk,
    input  wire                          rst_n,
    input  wire  [DEPTH-1:0]             lt_vec,
    input  wire  [DEPTH-1:0]             eq_vec,
    input  wire  [DEPTH*DATA_WIDTH-1:0]  pay_vec,
    output logic                         found,
    output logic [POS_W-1:0]             position,
    output logic [DATA_WIDTH-1:0]        pay
);
    import sktab_pkg::*;

    localparam int GS = 16;
    localparam int NG = (DEPTH + GS - 1) / GS;

    logic [DEPTH-1:0]      bound;
    logic [NG-1:0]         g_bhit_reg, g_bhit_next;
    logic [NG-1:0]         g_ehit_reg, g_ehit_next;
    logic [POS_W-1:0]      g_pos_reg [NG];
    logic [POS_W-1:0]      g_pos_next [NG];
    logic [DATA_WIDTH-1:0] g_pay_reg [NG];
    logic [DATA_WIDTH-1:0] g_pay_next [NG];
    logic                  found_reg, found_next;
    logic [POS_W-1:0]      pos_reg, pos_next;
    logic [DATA_WIDTH-1:0] pay_reg, pay_next;

    // Mark the first slot whose key is not below the request
    always_comb
    begin
        for (int i = 0; i < DEPTH; i++)
        begin
            if (i == 0)
                bound[i] = !lt_vec[i];
            else
                bound[i] = !lt_vec[i] && lt_vec[i-1];
        end
    end

    // First level: fold each group of sixteen slots
    always_comb
    begin
        for (int g = 0; g < NG; g++)
        begin
            g_bhit_next[g] = 1'b0;
            g_ehit_next[g] = 1'b0;
            g_pos_next[g]  = '0;
            g_pay_next[g]  = '0;
            for (int j = 0; j < GS; j++)
            begin
                if (g * GS + j < DEPTH)
                begin
                    if (bound[g*GS+j])
                    begin
                        g_bhit_next[g] = 1'b1;
                        g_pos_next[g]  = g_pos_next[g] | POS_W'(g * GS + j);
                    end
                    if (eq_vec[g*GS+j])
                    begin
                        g_ehit_next[g] = 1'b1;
                        g_pay_next[g]  = g_pay_next[g] |
                                         pay_vec[(g*GS+j)*DATA_WIDTH +: DATA_WIDTH];
                    end
                end
            end
        end
    end

    // Second level: fold the groups; no boundary means every slot is below
    always_comb
    begin
        found_next = |g_ehit_reg;
        pos_next   = '0;
        pay_next   = '0;
        for (int g = 0; g < NG; g++)
        begin
            if (g_bhit_reg[g])
                pos_next = pos_next | g_pos_reg[g];
            if (g_ehit_reg[g])
                pay_next = pay_next | g_pay_reg[g];
        end
        if (!(|g_bhit_reg))
            pos_next = POS_W'(DEPTH);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            g_bhit_reg <= '0;
            g_ehit_reg <= '0;
            found_reg  <= 1'b0;
        end
        else
        begin
            g_bhit_reg <= g_bhit_next;
            g_ehit_reg <= g_ehit_next;
            found_reg  <= found_next;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int g = 0; g < NG; g++)
        begin
            g_pos_reg[g] <= g_pos_next[g];
            g_pay_reg[g] <= g_pay_next[g];
        end
        pos_reg <= pos_next;
        pay_reg <= pay_next;
    end

    assign found    = found_reg;
    assign position = pos_reg;
    assign pay      = pay_reg;

endmodule

`default_nettype wire

// ===== sv/sorted_key_table.sv =====
// Top level of the sorted key table: request sequencer, cell row and result register.
//
//  channel  | direction | payload       | handshake
//  ---------+-----------+---------------+------------------------------
//  in       | input     | sktab_in_t    | in_valid / in_stall
//  out      | output    | sktab_out_t   | out_valid / out_stall
//  cfg      | input     | compare_signed| cfg_we (single register)
//
// A transaction passes through acceptance, compare in every cell, two levels of the
// flag tree, then the decision that shifts the cell row and loads the result. One
// request is in flight at a time; in_stall is high from acceptance to the decision. A
// result waiting under out_stall does not block the next request until its decision.
// Reset clears the entry count and the compare mode; slot contents need no reset.
`default_nettype none

module sorted_key_table #(
    parameter int DEPTH      = 256,
    parameter int KEY_WIDTH  = 32,
    parameter int DATA_WIDTH = 32
) (
    input  wire                    clk,
    input  wire                    rst_n,
    input  wire                    in_valid,
    output logic                   in_stall,
    input  sktab_pkg::sktab_in_t   in_data,
    output logic                   out_valid,
    input  wire                    out_stall,
    output sktab_pkg::sktab_out_t  out_data,
    input  wire                    cfg_we,
    input  wire                    cfg_wdata
);
    import sktab_pkg::*;

    localparam int POS_W = $clog2(DEPTH + 1);
    localparam logic [KEY_WIDTH-1:0] SIGN_MASK = KEY_WIDTH'(1) << (KEY_WIDTH - 1);

    sktab_state_t          state_reg, state_next;
    sktab_in_t             req_reg;
    logic                  cmp_signed_reg;
    logic [POS_W-1:0]      count_reg, count_next;
    logic                  out_valid_reg, out_valid_next;
    sktab_out_t            out_reg, out_next;
    sktab_ctl_t            ctl;

    logic [KEY_WIDTH-1:0]  req_key;
    logic [DATA_WIDTH-1:0] req_pay;
    logic [KEY_WIDTH-1:0]  want_key;

    logic [KEY_WIDTH-1:0]  cell_key [DEPTH];
    logic [DATA_WIDTH-1:0] cell_pay [DEPTH];
    logic [DEPTH-1:0]      lt_vec;
    logic [DEPTH-1:0]      eq_vec;
    logic [DEPTH*DATA_WIDTH-1:0] pay_vec;

    logic                  hit;
    logic [POS_W-1:0]      hit_pos;
    logic [DATA_WIDTH-1:0] hit_pay;

    logic                  slot_free;
    logic                  full;
    logic                  do_ins;
    logic                  do_del;
    sktab_status_t         status;
    logic [DATA_WIDTH-1:0] result_pay;

    // Trim the request to the table widths and map it into the compare order
    assign req_key  = KEY_WIDTH'(req_reg.key);
    assign req_pay  = DATA_WIDTH'(req_reg.payload_in);
    assign want_key = req_key ^ (cmp_signed_reg ? SIGN_MASK : '0);

    // Row of slots, each linked to its neighbors
    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        logic [KEY_WIDTH-1:0]  l_key, r_key;
        logic [DATA_WIDTH-1:0] l_pay, r_pay;
        logic                  l_lt;

        if (i == 0)
        begin : g_first
            assign l_key = req_key;
            assign l_pay = req_pay;
            assign l_lt  = 1'b1;
        end
        else
        begin : g_mid
            assign l_key = cell_key[i-1];
            assign l_pay = cell_pay[i-1];
            assign l_lt  = lt_vec[i-1];
        end

        if (i == DEPTH - 1)
        begin : g_last
            assign r_key = cell_key[i];
            assign r_pay = cell_pay[i];
        end
        else
        begin : g_inner
            assign r_key = cell_key[i+1];
            assign r_pay = cell_pay[i+1];
        end

        sktab_cell #(
            .KEY_WIDTH  (KEY_WIDTH),
            .DATA_WIDTH (DATA_WIDTH),
            .POS_W      (POS_W),
            .INDEX      (i)
        ) u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .ctl        (ctl),
            .cmp_signed (cmp_signed_reg),
            .want_key   (want_key),
            .new_key    (req_key),
            .new_pay    (req_pay),
            .count      (count_reg),
            .left_key   (l_key),
            .left_pay   (l_pay),
            .left_lt    (l_lt),
            .right_key  (r_key),
            .right_pay  (r_pay),
            .key        (cell_key[i]),
            .pay        (cell_pay[i]),
            .lt         (lt_vec[i]),
            .eq         (eq_vec[i])
        );

        assign pay_vec[i*DATA_WIDTH +: DATA_WIDTH] = cell_pay[i];
    end

    sktab_reduce #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH),
        .POS_W      (POS_W)
    ) u_reduce (
        .clk      (clk),
        .rst_n    (rst_n),
        .lt_vec   (lt_vec),
        .eq_vec   (eq_vec),
        .pay_vec  (pay_vec),
        .found    (hit),
        .position (hit_pos),
        .pay      (hit_pay)
    );

    // Decide the request outcome from the search result
    always_comb
    begin
        full       = count_reg == POS_W'(DEPTH);
        do_ins     = 1'b0;
        do_del     = 1'b0;
        status     = STAT_OK;
        result_pay = '0;
        case (req_reg.mode)
            MODE_INSERT:
            begin
                if (full)
                    status = STAT_FULL;
                else if (hit)
                    status = STAT_DUPLICATE;
                else
                    do_ins = 1'b1;
            end
            MODE_DELETE:
            begin
                if (hit)
                    do_del = 1'b1;
                else
                    status = STAT_NOT_FOUND;
            end
            default:
            begin
                if (hit)
                    result_pay = hit_pay;
                else
                    status = STAT_NOT_FOUND;
            end
        endcase
    end

    // Sequence one request through compare, tree and decision
    always_comb
    begin
        slot_free      = !out_valid_reg || !out_stall;
        state_next     = state_reg;
        count_next     = count_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && out_stall;
        ctl            = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                    state_next = S_CMP;
            end
            S_CMP:
            begin
                ctl.capture = 1'b1;
                state_next  = S_RED1;
            end
            S_RED1:
            begin
                state_next = S_RED2;
            end
            S_RED2:
            begin
                state_next = S_DEC;
            end
            S_DEC:
            begin
                if (slot_free)
                begin
                    ctl.ins = do_ins;
                    ctl.del = do_del;
                    if (do_ins)
                        count_next = count_reg + POS_W'(1);
                    else if (do_del)
                        count_next = count_reg - POS_W'(1);
                    out_next.status      = status;
                    out_next.position    = 9'(hit_pos);
                    out_next.payload_out = 32'(result_pay);
                    out_next.entry_count = 9'(count_next);
                    out_valid_next       = 1'b1;
                    state_next           = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            count_reg      <= '0;
            out_valid_reg  <= 1'b0;
            cmp_signed_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
                cmp_signed_reg <= cfg_wdata;
        end
    end

    // Capture the request on acceptance; hold the result payload
    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && in_valid)
            req_reg <= in_data;
        out_reg <= out_next;
    end

    assign in_stall  = state_reg != S_IDLE;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

endmodule

`default_nettype wire

// ===== bench/sorted_key_table_test.sv =====
// Self-checking testbench for the sorted key table: shadow table, random traffic, result scoreboard.
module sorted_key_table_test;
    import sktab_pkg::*;

    localparam int TABLE_DEPTH = 256;
    localparam int CFG_SETTLE = 8;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int MAX_PRINTED = 40;
    // Mode code with no name in the package; the block treats it as a search
    localparam logic [1:0] MODE_RESERVED = 2'd3;

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_stall;
    sktab_in_t in_data;
    logic out_valid;
    logic out_stall;
    sktab_out_t out_data;
    logic cfg_we;
    logic cfg_wdata;

    sorted_key_table DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    // Shadow copy of the table and the compare mode
    logic [31:0] shadow_keys [0:TABLE_DEPTH-1];
    logic [31:0] shadow_payloads [0:TABLE_DEPTH-1];
    int shadow_count = 0;
    bit compare_signed_cfg = 1'b0;

    sktab_out_t results_due [$];
    int mismatch_count = 0;
    int request_count = 0;
    int result_count = 0;
    int full_rejects = 0;
    int peak_fill = 0;
    int cfg_writes = 0;
    int burst_left = 0;
    int idle_cycles = 0;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Map a key onto an unsigned scale that follows the current compare mode
    function automatic logic [31:0] ordered_key(input logic [31:0] k);
        return compare_signed_cfg ? (k ^ 32'h8000_0000) : k;
    endfunction

    // Binary search of the shadow table: index if present, else insertion point
    function automatic bit locate_key(input logic [31:0] k, output int where);
        int lo;
        int hi;
        int mid;
        logic [31:0] want;
        logic [31:0] have;
        lo = 0;
        hi = shadow_count;
        want = ordered_key(k);
        while (lo < hi)
        begin
            mid = lo + (hi - lo) / 2;
            have = ordered_key(shadow_keys[mid]);
            if (want == have)
            begin
                where = mid;
                return 1'b1;
            end
            if (want < have)
                hi = mid;
            else
                lo = mid + 1;
        end
        where = lo;
        return 1'b0;
    endfunction

    // Apply one request to the shadow table and return the result it produces
    function automatic sktab_out_t apply_request(input sktab_in_t req);
        sktab_out_t res;
        int pos;
        bit hit;
        int i;
        res = '0;
        res.status = STAT_OK;
        hit = locate_key(req.key, pos);
        case (req.mode)
            MODE_INSERT:
            begin
                if (shadow_count >= TABLE_DEPTH)
                begin
                    res.status = STAT_FULL;
                    full_rejects++;
                end
                else if (hit)
                    res.status = STAT_DUPLICATE;
                else
                begin
                    for (i = shadow_count; i > pos; i--)
                    begin
                        shadow_keys[i] = shadow_keys[i-1];
                        shadow_payloads[i] = shadow_payloads[i-1];
                    end
                    shadow_keys[pos] = req.key;
                    shadow_payloads[pos] = req.payload_in;
                    shadow_count++;
                    if (shadow_count > peak_fill)
                        peak_fill = shadow_count;
                end
            end
            MODE_DELETE:
            begin
                if (!hit)
                    res.status = STAT_NOT_FOUND;
                else
                begin
                    for (i = pos; i + 1 < shadow_count; i++)
                    begin
                        shadow_keys[i] = shadow_keys[i+1];
                        shadow_payloads[i] = shadow_payloads[i+1];
                    end
                    shadow_count--;
                end
            end
            default:
            begin
                if (hit)
                    res.payload_out = shadow_payloads[pos];
                else
                    res.status = STAT_NOT_FOUND;
            end
        endcase
        res.position = pos[8:0];
        res.entry_count = shadow_count[8:0];
        return res;
    endfunction

    task automatic report_mismatch(input string msg);
        mismatch_count++;
        if (mismatch_count <= MAX_PRINTED)
            $display("ERROR at %0t: %s", $realtime, msg);
    endtask

    task automatic check_field(input string name, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want)
            report_mismatch($sformatf("result %0d %s: got 0x%0h, expected 0x%0h",
                                      result_count, name, got, want));
    endtask

    // Send one transaction; bursts of random length with random gaps between them
    task automatic send_request(input logic [1:0] mode, input logic [31:0] key,
                                input logic [31:0] pay);
        sktab_in_t req;
        req.mode = mode;
        req.key = key;
        req.payload_in = pay;
        if (burst_left == 0)
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                     : $urandom_range(1, 8);
        in_valid <= 1'b1;
        in_data <= req;
        do @(posedge clk); while (in_stall);
        results_due.push_back(apply_request(req));
        request_count++;
        burst_left--;
        if (burst_left == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
        end
    endtask

    // Drop valid and wait for every outstanding result
    task automatic wait_results_done();
        if (burst_left != 0)
        begin
            in_valid <= 1'b0;
            burst_left = 0;
        end
        while (results_due.size() != 0)
            @(posedge clk);
    endtask

    // Write the compare mode while the block is idle
    task automatic set_compare_mode(input bit signed_order);
        wait_results_done();
        repeat (CFG_SETTLE) @(posedge clk);
        cfg_we <= 1'b1;
        cfg_wdata <= signed_order;
        @(posedge clk);
        cfg_we <= 1'b0;
        compare_signed_cfg = signed_order;
        cfg_writes++;
    endtask

    // Keys clustered around the boundaries of both orders so collisions happen
    function automatic logic [31:0] random_key();
        case ($urandom_range(0, 5))
            0, 1: return $urandom;
            2: return $urandom_range(0, 15);
            3: return 32'h8000_0000 + $urandom_range(0, 15) - 8;
            4: return 32'hFFFF_FFFF - $urandom_range(0, 15);
            default: return 32'h7FFF_FFFF - $urandom_range(0, 15);
        endcase
    endfunction

    function automatic logic [31:0] stored_key();
        return shadow_keys[$urandom_range(0, shadow_count - 1)];
    endfunction

    function automatic logic [31:0] some_key(input int hit_percent);
        if (shadow_count > 0 && $urandom_range(0, 99) < hit_percent)
            return stored_key();
        return random_key();
    endfunction

    // Remove every stored entry so the order can change safely
    task automatic drain_table();
        while (shadow_count > 0)
            send_request(MODE_DELETE, stored_key(), $urandom);
    endtask

    // Extremes of the unsigned order, duplicates, misses and the reserved mode
    task automatic test_directed_unsigned();
        send_request(MODE_SEARCH, 32'h0000_0000, 32'h0);
        send_request(MODE_DELETE, 32'hFFFF_FFFF, 32'h0);
        send_request(MODE_INSERT, 32'h8000_0000, 32'hFFFF_FFFF);
        send_request(MODE_INSERT, 32'h0000_0000, 32'h0000_0000);
        send_request(MODE_INSERT, 32'hFFFF_FFFF, 32'hA5A5_A5A5);
        send_request(MODE_INSERT, 32'h7FFF_FFFF, 32'h5A5A_5A5A);
        send_request(MODE_INSERT, 32'h8000_0000, 32'h1234_5678);
        send_request(MODE_SEARCH, 32'hFFFF_FFFF, 32'h0);
        send_request(MODE_SEARCH, 32'h0000_0001, 32'h0);
        send_request(MODE_RESERVED, 32'h0000_0000, 32'hFFFF_FFFF);
        send_request(MODE_RESERVED, 32'h0001_2345, 32'h0);
        send_request(MODE_DELETE, 32'h0000_0000, 32'h0);
        send_request(MODE_DELETE, 32'h0000_0000, 32'h0);
        send_request(MODE_SEARCH, 32'h8000_0000, 32'h0);
        send_request(MODE_DELETE, 32'hFFFF_FFFF, 32'h0);
        send_request(MODE_INSERT, 32'h0000_0000, 32'hFFFF_0000);
    endtask

    // Negative keys must sort below positive ones
    task automatic test_signed_order();
        send_request(MODE_INSERT, 32'hFFFF_FFFF, 32'h0000_FFFF);
        send_request(MODE_INSERT, 32'h8000_0000, 32'h8000_0001);
        send_request(MODE_INSERT, 32'h7FFF_FFFF, 32'h7FFF_FFFE);
        send_request(MODE_INSERT, 32'h0000_0000, 32'hFFFF_FFFF);
        send_request(MODE_SEARCH, 32'h8000_0000, 32'h0);
        send_request(MODE_SEARCH, 32'h7FFF_FFFF, 32'h0);
        send_request(MODE_SEARCH, 32'h0000_0001, 32'h0);
        send_request(MODE_INSERT, 32'hFFFF_FFFF, 32'h0);
    endtask

    // Random traffic: inserts mostly on fresh keys, searches and deletes mostly on stored keys
    task automatic test_random_traffic(input int count);
        int n;
        int op;
        for (n = 0; n < count; n++)
        begin
            op = $urandom_range(0, 99);
            if (op < 40)
                send_request(MODE_INSERT, some_key(20), $urandom);
            else if (op < 70)
                send_request(MODE_SEARCH, some_key(65), $urandom);
            else if (op < 95)
                send_request(MODE_DELETE, some_key(65), $urandom);
            else
                send_request(MODE_RESERVED, some_key(50), $urandom);
        end
    endtask

    // Fill to capacity, then hit the full-table rejects and the top position
    task automatic test_full_table();
        while (shadow_count < TABLE_DEPTH)
            send_request(MODE_INSERT, $urandom_range(1, 32'hFFFF_FFFE), $urandom);
        send_request(MODE_INSERT, stored_key(), $urandom);
        send_request(MODE_INSERT, 32'hFFFF_FFFF, $urandom);
        send_request(MODE_INSERT, 32'h0000_0000, $urandom);
        send_request(MODE_SEARCH, 32'hFFFF_FFFF, $urandom);
        send_request(MODE_SEARCH, 32'h0000_0000, $urandom);
        send_request(MODE_SEARCH, shadow_keys[TABLE_DEPTH-1], $urandom);
        send_request(MODE_RESERVED, shadow_keys[0], $urandom);
        send_request(MODE_DELETE, shadow_keys[TABLE_DEPTH/2], $urandom);
        send_request(MODE_INSERT, 32'hFFFF_FFFF, $urandom);
        send_request(MODE_SEARCH, 32'hFFFF_FFFF, $urandom);
        send_request(MODE_DELETE, 32'hFFFF_FFFF, $urandom);
        drain_table();
    endtask

    // Receiver stall pattern: free-running, random, or mostly stalled stretches
    initial
    begin : stall_pattern
        int style;
        int span;
        out_stall <= 1'b0;
        forever
        begin
            style = $urandom_range(0, 3);
            span = $urandom_range(20, 200);
            repeat (span)
            begin
                @(posedge clk);
                case (style)
                    0: out_stall <= 1'b0;
                    1: out_stall <= ($urandom_range(0, 1) == 1);
                    2: out_stall <= ($urandom_range(0, 3) == 0);
                    default: out_stall <= ($urandom_range(0, 9) < 8);
                endcase
            end
        end
    end

    // Compare each accepted result with the oldest prediction
    always @(posedge clk)
    begin : check_results
        sktab_out_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (results_due.size() == 0)
                report_mismatch($sformatf("result with nothing pending: 0x%0h", out_data));
            else
            begin
                want = results_due.pop_front();
                check_field("status", out_data.status, want.status);
                check_field("position", out_data.position, want.position);
                check_field("payload_out", out_data.payload_out, want.payload_out);
                check_field("entry_count", out_data.entry_count, want.entry_count);
            end
            result_count++;
        end
    end

    // End the run if nothing is accepted for too long
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("timeout: no transaction for %0d cycles, %0d results pending",
                     idle_cycles, results_due.size());
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial
    begin
        rst_n <= 1'b0;
        in_valid <= 1'b0;
        in_data <= '0;
        cfg_we <= 1'b0;
        cfg_wdata <= 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        set_compare_mode(1'b0);
        test_directed_unsigned();
        test_random_traffic(180);
        drain_table();

        set_compare_mode(1'b1);
        test_signed_order();
        test_random_traffic(200);
        drain_table();

        set_compare_mode(1'b0);
        test_full_table();

        set_compare_mode(1'b1);
        test_random_traffic(160);

        wait_results_done();
        repeat (20) @(posedge clk);
        $display("Ran %0d requests, checked %0d results, %0d full-table rejects, peak fill %0d",
                 request_count, result_count, full_rejects, peak_fill);
        $display("Compare mode written %0d times across unsigned and signed key order",
                 cfg_writes);
        if (mismatch_count == 0 && results_due.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
